FILE: hw/rtl/yfmrc_pkg.sv
package yfmrc_pkg;

	localparam int PixW = 8;
	localparam int RowW = 10;
	localparam int HeightW = 11;
	localparam int TotalW = 21;
	localparam int SumW = 30;
	localparam int CentW = 11;
	localparam int AddrW = 5;
	localparam int DataW = 32;
	localparam int CntW = $clog2(SumW);

	localparam logic [TotalW-1:0] TotalLimit = {TotalW{1'b1}};

	// reset values of the threshold registers
	localparam logic [PixW-1:0] LumaMinRst = 8'd50;
	localparam logic [PixW-1:0] LumaMaxRst = 8'd255;
	localparam logic [PixW-1:0] BlueMinRst = 8'd0;
	localparam logic [PixW-1:0] BlueMaxRst = 8'd140;
	localparam logic [PixW-1:0] RedMinRst = 8'd100;
	localparam logic [PixW-1:0] RedMaxRst = 8'd255;
	localparam logic [HeightW-1:0] HeightRst = 11'd200;

	typedef enum logic [2:0] {
		REG_LUMA_MIN = 3'd0,
		REG_LUMA_MAX = 3'd1,
		REG_BLUE_MIN = 3'd2,
		REG_BLUE_MAX = 3'd3,
		REG_RED_MIN  = 3'd4,
		REG_RED_MAX  = 3'd5,
		REG_HEIGHT   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [PixW-1:0]    luma_min;
		logic [PixW-1:0]    luma_max;
		logic [PixW-1:0]    blue_chroma_min;
		logic [PixW-1:0]    blue_chroma_max;
		logic [PixW-1:0]    red_chroma_min;
		logic [PixW-1:0]    red_chroma_max;
		logic [HeightW-1:0] frame_height;
	} cfg_t;

	typedef struct packed {
		logic accept;    // input request taken this cycle
		logic start_div; // frame end taken: load divider, clear accumulators
		logic div_step;  // one restoring division step
		logic out_load;  // place count and centroid in the result register
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_last;  // current step is the final quotient bit
		logic out_free;  // result register may be loaded this cycle
	} dp_status_t;

endpackage

FILE: hw/rtl/yfmrc_pix_if.sv
interface yfmrc_pix_if;
	logic                        valid;
	logic                        ready;
	logic [yfmrc_pkg::PixW-1:0]  blue_chroma;
	logic [yfmrc_pkg::PixW-1:0]  luma_first;
	logic [yfmrc_pkg::PixW-1:0]  red_chroma;
	logic [yfmrc_pkg::PixW-1:0]  luma_second;
	logic [yfmrc_pkg::RowW-1:0]  row_index;
	logic                        frame_end;

	modport source (
		output valid, blue_chroma, luma_first, red_chroma, luma_second, row_index, frame_end,
		input ready
	);
	modport sink (
		input valid, blue_chroma, luma_first, red_chroma, luma_second, row_index, frame_end,
		output ready
	);
endinterface

FILE: hw/rtl/yfmrc_res_if.sv
interface yfmrc_res_if;
	logic                               valid;
	logic                               ready;
	logic [yfmrc_pkg::TotalW-1:0]       floor_pixels;
	logic signed [yfmrc_pkg::CentW-1:0] row_offset;

	modport source (output valid, floor_pixels, row_offset, input ready);
	modport sink (input valid, floor_pixels, row_offset, output ready);
endinterface

FILE: hw/rtl/yuv_floor_mask_row_centroid_top.sv
// floor colour mask with row centroid over a uyvy stream. each pixel request carries one
// macropixel (shared u and v, two luma samples, row index and a frame-end flag); each of the
// two pixels counts as floor when its luma and the pair's u and v sit inside the inclusive
// ranges held in the apb registers (luma_min 0x00, luma_max 0x04, blue_chroma_min 0x08,
// blue_chroma_max 0x0c, red_chroma_min 0x10, red_chroma_max 0x14, frame_height 0x18).
// floor pixels add to a saturating pixel count and row sum. the frame-end pair is counted
// first, then one result request gives the count and floor(frame_height/2) minus the mean
// floor row (0 when the count is zero), and the sums restart. ordinary pairs are taken one
// per cycle, also while a result waits. a frame-end pair closes the input while the
// restoring divider runs, one quotient bit a cycle, and until the result register is
// loaded; longer if the previous result has not yet been taken. write registers only
// while the block is idle.
module yuv_floor_mask_row_centroid_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [yfmrc_pkg::AddrW-1:0]   paddr,
	input  logic [yfmrc_pkg::DataW-1:0]   pwdata,
	output logic [yfmrc_pkg::DataW-1:0]   prdata,
	output logic                          pready,
	yfmrc_pix_if.sink                     pix,
	yfmrc_res_if.source                   res
);

	yfmrc_pkg::cfg_t       cfg;
	yfmrc_pkg::ctrl_cmd_t  cmd;
	yfmrc_pkg::dp_status_t status;

	// register bank, reads return the stored value
	yfmrc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: accept, divide, hand the result over
	yfmrc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (pix.valid),
		.in_frame_end (pix.frame_end),
		.in_ready     (pix.ready),
		.status       (status),
		.cmd          (cmd)
	);

	// classifier, accumulators, divider and result register
	yfmrc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.status (status),
		.pix    (pix),
		.res    (res)
	);

endmodule

FILE: hw/rtl/yfmrc_cfg.sv
module yfmrc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [yfmrc_pkg::AddrW-1:0]   paddr,
	input  logic [yfmrc_pkg::DataW-1:0]   pwdata,
	output logic [yfmrc_pkg::DataW-1:0]   prdata,
	output logic                          pready,
	output yfmrc_pkg::cfg_t               cfg
);

	yfmrc_pkg::cfg_t cfg_q;
	logic [2:0]      idx;
	logic            wr_en;

	assign idx    = paddr[yfmrc_pkg::AddrW-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.luma_min        <= yfmrc_pkg::LumaMinRst;
			cfg_q.luma_max        <= yfmrc_pkg::LumaMaxRst;
			cfg_q.blue_chroma_min <= yfmrc_pkg::BlueMinRst;
			cfg_q.blue_chroma_max <= yfmrc_pkg::BlueMaxRst;
			cfg_q.red_chroma_min  <= yfmrc_pkg::RedMinRst;
			cfg_q.red_chroma_max  <= yfmrc_pkg::RedMaxRst;
			cfg_q.frame_height    <= yfmrc_pkg::HeightRst;
		end else if (wr_en) begin
			case (idx)
				yfmrc_pkg::REG_LUMA_MIN: cfg_q.luma_min <= pwdata[7:0];
				yfmrc_pkg::REG_LUMA_MAX: cfg_q.luma_max <= pwdata[7:0];
				yfmrc_pkg::REG_BLUE_MIN: cfg_q.blue_chroma_min <= pwdata[7:0];
				yfmrc_pkg::REG_BLUE_MAX: cfg_q.blue_chroma_max <= pwdata[7:0];
				yfmrc_pkg::REG_RED_MIN:  cfg_q.red_chroma_min <= pwdata[7:0];
				yfmrc_pkg::REG_RED_MAX:  cfg_q.red_chroma_max <= pwdata[7:0];
				yfmrc_pkg::REG_HEIGHT:   cfg_q.frame_height <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			yfmrc_pkg::REG_LUMA_MIN: prdata[7:0] = cfg_q.luma_min;
			yfmrc_pkg::REG_LUMA_MAX: prdata[7:0] = cfg_q.luma_max;
			yfmrc_pkg::REG_BLUE_MIN: prdata[7:0] = cfg_q.blue_chroma_min;
			yfmrc_pkg::REG_BLUE_MAX: prdata[7:0] = cfg_q.blue_chroma_max;
			yfmrc_pkg::REG_RED_MIN:  prdata[7:0] = cfg_q.red_chroma_min;
			yfmrc_pkg::REG_RED_MAX:  prdata[7:0] = cfg_q.red_chroma_max;
			yfmrc_pkg::REG_HEIGHT:   prdata[10:0] = cfg_q.frame_height;
			default:                 prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/yfmrc_ctrl.sv
module yfmrc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_frame_end,
	output logic                   in_ready,
	input  yfmrc_pkg::dp_status_t  status,
	output yfmrc_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_DIVIDE = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.accept    = in_ready & in_valid;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept && in_frame_end) begin
					cmd.start_div = 1'b1;
					state_d       = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// wait for the result register to drain
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: hw/rtl/yfmrc_dp.sv
module yfmrc_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  yfmrc_pkg::cfg_t        cfg,
	input  yfmrc_pkg::ctrl_cmd_t   cmd,
	output yfmrc_pkg::dp_status_t  status,
	yfmrc_pix_if.sink              pix,
	yfmrc_res_if.source            res
);

	localparam int TotalW = yfmrc_pkg::TotalW;
	localparam int SumW   = yfmrc_pkg::SumW;
	localparam int RowW   = yfmrc_pkg::RowW;
	localparam int CentW  = yfmrc_pkg::CentW;
	localparam int CntW   = yfmrc_pkg::CntW;

	// accumulators
	logic [TotalW-1:0] pixel_total_q;
	logic [SumW-1:0]   row_sum_q;
	// divider
	logic [SumW-1:0]   dvd_q;
	logic [TotalW-1:0] dvs_q;
	logic [TotalW-1:0] rem_q;
	logic [CentW-1:0]  quo_q;
	logic [CntW-1:0]   cnt_q;
	// result register
	logic                    out_valid_q;
	logic [TotalW-1:0]       floor_pixels_q;
	logic [CentW-1:0]        row_offset_q;

	logic              chroma_ok, pass0, pass1;
	logic [1:0]        n_pix;
	logic [TotalW:0]   total_sum;
	logic [TotalW-1:0] total_next;
	logic [RowW:0]     row_add;
	logic [SumW:0]     sum_sum;
	logic [SumW-1:0]   sum_next;
	logic [TotalW:0]   rem_shift;
	logic [TotalW:0]   rem_diff;
	logic              q_bit;
	logic [CentW-1:0]  centroid;

	// classification of both pixels of the pair
	assign chroma_ok = (pix.blue_chroma >= cfg.blue_chroma_min)
		&& (pix.blue_chroma <= cfg.blue_chroma_max)
		&& (pix.red_chroma >= cfg.red_chroma_min)
		&& (pix.red_chroma <= cfg.red_chroma_max);
	assign pass0 = chroma_ok && (pix.luma_first >= cfg.luma_min)
		&& (pix.luma_first <= cfg.luma_max);
	assign pass1 = chroma_ok && (pix.luma_second >= cfg.luma_min)
		&& (pix.luma_second <= cfg.luma_max);
	assign n_pix = {1'b0, pass0} + {1'b0, pass1};

	// saturating accumulate
	assign total_sum  = {1'b0, pixel_total_q} + {{(TotalW-1){1'b0}}, n_pix};
	assign total_next = total_sum[TotalW] ? yfmrc_pkg::TotalLimit : total_sum[TotalW-1:0];
	assign row_add    = n_pix[1] ? {pix.row_index, 1'b0}
		: (n_pix[0] ? {1'b0, pix.row_index} : '0);
	assign sum_sum    = {1'b0, row_sum_q} + {{(SumW-RowW){1'b0}}, row_add};
	assign sum_next   = sum_sum[SumW] ? {SumW{1'b1}} : sum_sum[SumW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_total_q <= '0;
			row_sum_q     <= '0;
		end else if (cmd.start_div) begin
			pixel_total_q <= '0;
			row_sum_q     <= '0;
		end else if (cmd.accept) begin
			pixel_total_q <= total_next;
			row_sum_q     <= sum_next;
		end
	end

	// restoring division, one quotient bit a step
	assign rem_shift = {rem_q, dvd_q[SumW-1]};
	assign rem_diff  = rem_shift - {1'b0, dvs_q};
	assign q_bit     = (rem_shift >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start_div) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			dvd_q <= sum_next;
			dvs_q <= total_next;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[SumW-2:0], 1'b0};
			rem_q <= q_bit ? rem_diff[TotalW-1:0] : rem_shift[TotalW-1:0];
			quo_q <= {quo_q[CentW-2:0], q_bit};
		end
	end

	assign status.div_last = (cnt_q == CntW'(SumW - 1));
	assign status.out_free = !out_valid_q || res.ready;

	// only the low bits of the mean reach the wrapped centroid
	assign centroid = (dvs_q == '0) ? '0
		: ({1'b0, cfg.frame_height[CentW-1:1]} - quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			floor_pixels_q <= dvs_q;
			row_offset_q   <= centroid;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.floor_pixels = floor_pixels_q;
	assign res.row_offset   = row_offset_q;

endmodule

FILE: hw/rtl/yfmrc_checker.sv
module yfmrc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               in_frame_end,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [yfmrc_pkg::TotalW-1:0]       out_pixels,
	input logic [yfmrc_pkg::CentW-1:0]        out_centroid
);

	// a waiting result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped while stalled");

	// the divider keeps the input closed after a frame end
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_frame_end |=> !in_ready ##1 !in_ready)
		else $error("input reopened during division");

	// a new result appears only as the sequencer leaves its busy states
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised without a finished division");

	// no floor pixels means a zero centroid
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_pixels == '0) |-> (out_centroid == '0))
		else $error("nonzero centroid on an empty frame");

endmodule

bind yuv_floor_mask_row_centroid_top yfmrc_checker u_yfmrc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (pix.valid),
	.in_ready     (pix.ready),
	.in_frame_end (pix.frame_end),
	.out_valid    (res.valid),
	.out_ready    (res.ready),
	.out_pixels   (res.floor_pixels),
	.out_centroid (res.row_offset)
);
